// ===== hdl/bresenham_line_stepper_macros.svh =====
// Assertion macros for the line stepper, sampled on clk.
`ifndef BRESENHAM_LINE_STEPPER_MACROS_SVH
`define BRESENHAM_LINE_STEPPER_MACROS_SVH

// Checked outside reset only.
`define BLS_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Checked on every edge, reset included.
`define BLS_ASSERT_RST(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ===== hdl/bls_pkg.sv =====
// Shared constants and width helpers for the line stepper.
`default_nettype none

package bls_pkg;

  localparam logic OP_START = 1'b0;
  localparam logic OP_STEP  = 1'b1;

  // Bits of one classified command: start flag, four coordinates,
  // two step signs, steep flag and the signed decision term.
  function automatic int cmd_bits(input int coord_bits);
    return 1 + 4 * coord_bits + 3 + coord_bits + 3;
  endfunction

endpackage

`default_nettype wire

// ===== hdl/bls_front.sv =====
// Front end: takes requests, classifies them and sets up line parameters.
`default_nettype none

module bls_front #(
  parameter int COORD_BITS = 10,
  parameter int IN_W       = 40,
  parameter int CMD_W      = 57
) (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             s_axis_tvalid,
  output logic                  s_axis_tready,
  input  wire logic [IN_W-1:0]  s_axis_tdata,
  input  wire logic             s_axis_tuser,
  output logic                  f_valid,
  input  wire logic             f_ready,
  output logic [CMD_W-1:0]      f_cmd
);
  import bls_pkg::*;

  localparam int CB    = COORD_BITS;
  localparam int DEC_W = CB + 3;

  typedef struct packed {
    logic                    start;
    logic [CB-1:0]           x0;
    logic [CB-1:0]           y0;
    logic [CB-1:0]           major;
    logic [CB-1:0]           minor;
    logic                    xdown;
    logic                    ydown;
    logic                    steep;
    logic signed [DEC_W-1:0] decision;
  } cmd_t;

  logic [CB-1:0] x0, y0, x1, y1, ax, ay;
  cmd_t          cmd_next;
  cmd_t          cmd;

  assign x0 = s_axis_tdata[CB-1:0];
  assign y0 = s_axis_tdata[2*CB-1:CB];
  assign x1 = s_axis_tdata[3*CB-1:2*CB];
  assign y1 = s_axis_tdata[4*CB-1:3*CB];

  always_comb begin
    ax = (x1 >= x0) ? (x1 - x0) : (x0 - x1);
    ay = (y1 >= y0) ? (y1 - y0) : (y0 - y1);
    cmd_next.start = (s_axis_tuser == OP_START);
    cmd_next.x0    = x0;
    cmd_next.y0    = y0;
    cmd_next.xdown = (x1 < x0);
    cmd_next.ydown = (y1 < y0);
    cmd_next.steep = (ay > ax);
    cmd_next.major = cmd_next.steep ? ay : ax;
    cmd_next.minor = cmd_next.steep ? ax : ay;
    cmd_next.decision = $signed({2'b00, cmd_next.minor, 1'b0})
                      - $signed({3'b000, cmd_next.major});
  end

  assign s_axis_tready = !f_valid || f_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      f_valid <= 1'b0;
    end else if (s_axis_tready) begin
      f_valid <= s_axis_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (s_axis_tready && s_axis_tvalid) begin
      cmd <= cmd_next;
    end
  end

  assign f_cmd = cmd;

endmodule

`default_nettype wire

// ===== hdl/bls_queue.sv =====
// Two-entry command queue between front end and stepper.
`default_nettype none

module bls_queue #(
  parameter int WIDTH = 57
) (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             in_valid,
  output logic                  in_ready,
  input  wire logic [WIDTH-1:0] in_data,
  output logic                  out_valid,
  input  wire logic             out_ready,
  output logic [WIDTH-1:0]      out_data
);

  logic [WIDTH-1:0] slots [2];
  logic             wr_ptr;
  logic             rd_ptr;
  logic [1:0]       count;
  logic             push;
  logic             pop;

  assign in_ready  = (count != 2'd2);
  assign out_valid = (count != 2'd0);
  assign push      = in_valid && in_ready;
  assign pop       = out_valid && out_ready;
  assign out_data  = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (push) wr_ptr <= ~wr_ptr;
      if (pop) rd_ptr <= ~rd_ptr;
      if (push && !pop) begin
        count <= count + 2'd1;
      end else if (pop && !push) begin
        count <= count - 2'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= in_data;
    end
  end

endmodule

`default_nettype wire

// ===== hdl/bls_back.sv =====
// Stepper: holds the active line, walks it and registers each pixel.
`default_nettype none

module bls_back #(
  parameter int COORD_BITS = 10,
  parameter int OUT_W      = 24,
  parameter int CMD_W      = 57
) (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             q_valid,
  output logic                  q_ready,
  input  wire logic [CMD_W-1:0] q_data,
  output logic                  m_axis_tvalid,
  input  wire logic             m_axis_tready,
  output logic [OUT_W-1:0]      m_axis_tdata,
  output logic                  m_axis_tlast,
  output logic                  m_axis_tuser,
  output logic                  line_active
);
  import bls_pkg::*;

  localparam int CB    = COORD_BITS;
  localparam int DEC_W = CB + 3;

  typedef struct packed {
    logic                    start;
    logic [CB-1:0]           x0;
    logic [CB-1:0]           y0;
    logic [CB-1:0]           major;
    logic [CB-1:0]           minor;
    logic                    xdown;
    logic                    ydown;
    logic                    steep;
    logic signed [DEC_W-1:0] decision;
  } cmd_t;

  cmd_t                    cmd;
  logic [CB-1:0]           cur_x, cur_y, major_delta, minor_delta, steps_left;
  logic signed [DEC_W-1:0] decision;
  logic                    xdown, ydown, steep, active;
  logic                    out_valid;
  logic [CB-1:0]           px, py;
  logic                    last, pvalid;

  logic                    pop;
  logic                    minor_step;
  logic signed [DEC_W-1:0] two_minor, two_diff, decision_next;
  logic [CB-1:0]           x_moved, y_moved, cur_x_next, cur_y_next;
  logic                    step_last;

  assign cmd     = cmd_t'(q_data);
  assign q_ready = !out_valid || m_axis_tready;
  assign pop     = q_valid && q_ready;

  always_comb begin
    minor_step    = !decision[DEC_W-1];
    two_minor     = $signed({2'b00, minor_delta, 1'b0});
    two_diff      = two_minor - $signed({2'b00, major_delta, 1'b0});
    decision_next = decision + (minor_step ? two_diff : two_minor);
    x_moved       = xdown ? (cur_x - 1'b1) : (cur_x + 1'b1);
    y_moved       = ydown ? (cur_y - 1'b1) : (cur_y + 1'b1);
    if (steep) begin
      cur_y_next = y_moved;
      cur_x_next = minor_step ? x_moved : cur_x;
    end else begin
      cur_x_next = x_moved;
      cur_y_next = minor_step ? y_moved : cur_y;
    end
    step_last = (steps_left == CB'(1));
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid   <= 1'b0;
      active      <= 1'b0;
      cur_x       <= '0;
      cur_y       <= '0;
      decision    <= '0;
      major_delta <= '0;
      minor_delta <= '0;
      steps_left  <= '0;
      xdown       <= 1'b0;
      ydown       <= 1'b0;
      steep       <= 1'b0;
    end else begin
      if (pop) begin
        out_valid <= 1'b1;
      end else if (m_axis_tready) begin
        out_valid <= 1'b0;
      end
      if (pop) begin
        if (cmd.start) begin
          cur_x       <= cmd.x0;
          cur_y       <= cmd.y0;
          decision    <= cmd.decision;
          major_delta <= cmd.major;
          minor_delta <= cmd.minor;
          steps_left  <= cmd.major;
          xdown       <= cmd.xdown;
          ydown       <= cmd.ydown;
          steep       <= cmd.steep;
          active      <= (cmd.major != '0);
        end else if (active) begin
          cur_x      <= cur_x_next;
          cur_y      <= cur_y_next;
          decision   <= decision_next;
          steps_left <= steps_left - 1'b1;
          active     <= !step_last;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      if (cmd.start) begin
        px     <= cmd.x0;
        py     <= cmd.y0;
        last   <= (cmd.major == '0);
        pvalid <= 1'b1;
      end else if (active) begin
        px     <= cur_x_next;
        py     <= cur_y_next;
        last   <= step_last;
        pvalid <= 1'b1;
      end else begin
        px     <= '0;
        py     <= '0;
        last   <= 1'b0;
        pvalid <= 1'b0;
      end
    end
  end

  always_comb begin
    m_axis_tdata           = '0;
    m_axis_tdata[2*CB-1:0] = {py, px};
  end

  assign m_axis_tvalid = out_valid;
  assign m_axis_tlast  = last;
  assign m_axis_tuser  = pvalid;
  assign line_active   = active;

endmodule

`default_nettype wire

// ===== hdl/bresenham_line_stepper.sv =====
// Top level of the Bresenham line stepper: front end, queue and stepper.
// Usage:
//   Requests enter on the s_axis channel. tuser is the opcode: 0 starts a
//   line from the endpoints in tdata and returns the start pixel, 1 returns
//   the next pixel of the active line. A step with no active line returns a
//   result with tuser low and zero pixel fields.
//   Results leave on m_axis: tdata holds the pixel, tlast marks the end
//   point of the line, tuser is high for a real pixel.
//   One request is taken per cycle while the receiver keeps tready high, and
//   each gives exactly one result; the stepper's add-and-compare per pixel
//   is combinational, ahead of its output register. A request passes the
//   front register, the two-entry queue and that output register to its result.
//   When the receiver holds tready low the output register keeps its
//   result, the queue fills, and s_axis_tready drops once the front
//   register is also occupied; no request is lost.
//   Reset empties all stages and drops any active line.
`default_nettype none
`include "bresenham_line_stepper_macros.svh"

module bresenham_line_stepper #(
  parameter int COORD_BITS = 10
) (
  input  wire logic                                     clk,
  input  wire logic                                     rst,
  input  wire logic                                     s_axis_tvalid,
  output logic                                          s_axis_tready,
  // start_x, start_y, end_x, end_y (lowest bits first), zero padded
  input  wire logic [((4*COORD_BITS+7)/8)*8-1:0]         s_axis_tdata,
  // opcode
  input  wire logic                                     s_axis_tuser,
  output logic                                          m_axis_tvalid,
  input  wire logic                                     m_axis_tready,
  // pixel_x, pixel_y (lowest bits first), zero padded
  output logic [((2*COORD_BITS+7)/8)*8-1:0]              m_axis_tdata,
  // is_last
  output logic                                          m_axis_tlast,
  // pixel_valid
  output logic                                          m_axis_tuser
);
  import bls_pkg::*;

  localparam int IN_W  = ((4*COORD_BITS+7)/8)*8;
  localparam int OUT_W = ((2*COORD_BITS+7)/8)*8;
  localparam int CMD_W = cmd_bits(COORD_BITS);

  logic             f_valid, f_ready;
  logic [CMD_W-1:0] f_cmd;
  logic             q_valid, q_ready;
  logic [CMD_W-1:0] q_data;
  logic             line_active;

  bls_front #(
    .COORD_BITS(COORD_BITS),
    .IN_W      (IN_W),
    .CMD_W     (CMD_W)
  ) u_front (
    .clk          (clk),
    .rst          (rst),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .s_axis_tuser (s_axis_tuser),
    .f_valid      (f_valid),
    .f_ready      (f_ready),
    .f_cmd        (f_cmd)
  );

  bls_queue #(
    .WIDTH(CMD_W)
  ) u_queue (
    .clk      (clk),
    .rst      (rst),
    .in_valid (f_valid),
    .in_ready (f_ready),
    .in_data  (f_cmd),
    .out_valid(q_valid),
    .out_ready(q_ready),
    .out_data (q_data)
  );

  bls_back #(
    .COORD_BITS(COORD_BITS),
    .OUT_W     (OUT_W),
    .CMD_W     (CMD_W)
  ) u_back (
    .clk          (clk),
    .rst          (rst),
    .q_valid      (q_valid),
    .q_ready      (q_ready),
    .q_data       (q_data),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .m_axis_tlast (m_axis_tlast),
    .m_axis_tuser (m_axis_tuser),
    .line_active  (line_active)
  );

  `BLS_ASSERT(a_invalid_zero, m_axis_tvalid && !m_axis_tuser |-> m_axis_tdata == '0 && !m_axis_tlast, "invalid pixel carries data")
  `BLS_ASSERT(a_last_idle, m_axis_tvalid && m_axis_tlast |-> !line_active, "line still active after its last pixel")
  `BLS_ASSERT(a_front_hold, f_valid && !f_ready |=> f_valid && $stable(f_cmd), "front command lost while queue full")
  `BLS_ASSERT_RST(a_reset_empty, rst |=> !m_axis_tvalid && !f_valid && !q_valid, "pipeline not empty after reset")

endmodule

`default_nettype wire

// ===== verif/tb_bresenham_line_stepper.sv =====
// Testbench for bresenham_line_stepper: directed table, then random line runs checked against a predictor.
`timescale 1ns / 100ps

module tb_bresenham_line_stepper;
  import bls_pkg::*;

  localparam int CB       = 10;
  localparam int DW       = CB + 3;
  localparam int S_W      = ((4*CB+7)/8)*8;
  localparam int M_W      = ((2*CB+7)/8)*8;
  localparam int MAXC     = (1 << CB) - 1;
  localparam int DIR_N    = 25;
  localparam int N_ITEMS  = 850;
  localparam int HOLD_AT  = 300;
  localparam int DRAIN_AT = 500;
  localparam int QUIET_AT = 760;
  localparam int HOLD_LEN = 80;

  typedef logic [CB-1:0] coord_t;
  typedef struct packed { logic op; coord_t sx, sy, ex, ey; } line_req_t;
  typedef struct packed { coord_t x, y; logic last, valid; } pixel_t;
  typedef struct { line_req_t req; bit typed; pixel_t pix; } dir_row_t;

  logic           clk = 1'b0;
  logic           rst = 1'b1;
  logic           s_axis_tvalid = 1'b0;
  logic           s_axis_tready;
  logic [S_W-1:0] s_axis_tdata = '0;
  logic           s_axis_tuser = 1'b0;
  logic           m_axis_tvalid;
  logic           m_axis_tready = 1'b0;
  logic [M_W-1:0] m_axis_tdata;
  logic           m_axis_tlast;
  logic           m_axis_tuser;

  bresenham_line_stepper #(.COORD_BITS(CB)) DUT (
    .clk(clk), .rst(rst),
    .s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
    .s_axis_tdata(s_axis_tdata), .s_axis_tuser(s_axis_tuser),
    .m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
    .m_axis_tdata(m_axis_tdata), .m_axis_tlast(m_axis_tlast),
    .m_axis_tuser(m_axis_tuser)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  initial begin
    repeat (5) @(posedge clk);
    rst <= 1'b0;
  end

  initial begin
    #2000000;
    $display("status: fail");
    $finish;
  end

  // stepper state mirror
  coord_t                pr_x = '0, pr_y = '0;
  logic signed [DW-1:0]  pr_dec = '0;
  coord_t                pr_major = '0, pr_minor = '0;
  logic [CB:0]           pr_left = '0;
  logic [1:0]            pr_signs = '0;
  logic                  pr_steep = 1'b0, pr_active = 1'b0;

  pixel_t pending_pixels[$];
  int     err_count = 0;
  int     req_count = 0, starts_sent = 0, lines_done = 0, idle_steps = 0;
  bit     tx_idle = 1'b1, rx_idle = 1'b1, hold_req = 1'b0;

  function automatic coord_t nudge(coord_t v, logic down);
    return down ? v - 1'b1 : v + 1'b1;
  endfunction

  function automatic pixel_t trace_pixel(line_req_t r);
    pixel_t p;
    coord_t ax, ay;
    logic   minor_step;
    p = '0;
    if (r.op == OP_START) begin
      ax = (r.ex >= r.sx) ? r.ex - r.sx : r.sx - r.ex;
      ay = (r.ey >= r.sy) ? r.ey - r.sy : r.sy - r.ey;
      pr_signs  = {r.ey < r.sy, r.ex < r.sx};
      pr_steep  = ay > ax;
      pr_major  = pr_steep ? ay : ax;
      pr_minor  = pr_steep ? ax : ay;
      pr_dec    = DW'(2 * int'(pr_minor) - int'(pr_major));
      pr_left   = {1'b0, pr_major};
      pr_x      = r.sx;
      pr_y      = r.sy;
      pr_active = pr_left != 0;
      p = '{x: pr_x, y: pr_y, last: !pr_active, valid: 1'b1};
    end else if (pr_active) begin
      minor_step = pr_dec >= 0;
      pr_dec = DW'(int'(pr_dec) + 2 * int'(pr_minor) - (minor_step ? 2 * int'(pr_major) : 0));
      if (pr_steep) begin
        pr_y = nudge(pr_y, pr_signs[1]);
        if (minor_step) pr_x = nudge(pr_x, pr_signs[0]);
      end else begin
        pr_x = nudge(pr_x, pr_signs[0]);
        if (minor_step) pr_y = nudge(pr_y, pr_signs[1]);
      end
      pr_left   = pr_left - 1'b1;
      pr_active = pr_left != 0;
      p = '{x: pr_x, y: pr_y, last: !pr_active, valid: 1'b1};
    end
    return p;
  endfunction

  function automatic line_req_t mk_req(logic op, int sx, int sy, int ex, int ey);
    return '{op: op, sx: coord_t'(sx), sy: coord_t'(sy), ex: coord_t'(ex), ey: coord_t'(ey)};
  endfunction

  function automatic pixel_t mk_pix(int x, int y, logic last, logic valid);
    return '{x: coord_t'(x), y: coord_t'(y), last: last, valid: valid};
  endfunction

  function automatic line_req_t junk_step();
    return mk_req(OP_STEP, $urandom_range(0, MAXC), $urandom_range(0, MAXC),
                  $urandom_range(0, MAXC), $urandom_range(0, MAXC));
  endfunction

  function automatic int pin(int v);
    return (v < 0) ? 0 : (v > MAXC) ? MAXC : v;
  endfunction

  task automatic send_req(input line_req_t r, input bit typed, input pixel_t typed_pix);
    pixel_t want;
    if (req_count >= QUIET_AT) begin
      tx_idle = 1'b0;
      rx_idle = 1'b0;
    end
    if (req_count == HOLD_AT) hold_req = 1'b1;
    if (req_count == DRAIN_AT) begin
      s_axis_tvalid <= 1'b0;
      wait (pending_pixels.size() == 0);
      @(posedge clk);
    end else if (tx_idle && $urandom_range(0, 5) == 0) begin
      s_axis_tvalid <= 1'b0;
      repeat ($urandom_range(1, 18)) @(posedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tuser  <= r.op;
    s_axis_tdata  <= {r.ey, r.ex, r.sy, r.sx};
    do @(posedge clk); while (!s_axis_tready);
    want = trace_pixel(r);
    if (typed) want = typed_pix;
    pending_pixels.push_back(want);
    req_count++;
    if (r.op == OP_START) starts_sent++;
  endtask

  // start, then steps: mostly to the end point, sometimes cut short or run past it
  task automatic run_line();
    line_req_t r;
    int        span, major, n, k;
    r = mk_req(OP_START, $urandom_range(0, MAXC), $urandom_range(0, MAXC), 0, 0);
    span = 12;
    case ($urandom_range(0, 19))
      0, 1: begin
        r.ex = $urandom_range(0, MAXC);
        r.ey = $urandom_range(0, MAXC);
      end
      2: begin
        r.ex = r.sx;
        r.ey = r.sy;
      end
      3, 4, 5: span = 60;
      default: ;
    endcase
    if (r.ex == 0 && r.ey == 0 && !(r.sx == 0 && r.sy == 0)) begin
      r.ex = coord_t'(pin(int'(r.sx) + int'($urandom_range(0, 2*span)) - span));
      r.ey = coord_t'(pin(int'(r.sy) + int'($urandom_range(0, 2*span)) - span));
    end
    major = (r.ex >= r.sx) ? r.ex - r.sx : r.sx - r.ex;
    if (((r.ey >= r.sy) ? r.ey - r.sy : r.sy - r.ey) > major)
      major = (r.ey >= r.sy) ? r.ey - r.sy : r.sy - r.ex + r.ex - r.ey;
    n = (major > 40) ? $urandom_range(0, 40) : major;
    k = $urandom_range(0, 99);
    if (k < 12) n = $urandom_range(0, n);
    else if (k < 25) n = n + $urandom_range(1, 3);
    send_req(r, 1'b0, '0);
    repeat (n) send_req(junk_step(), 1'b0, '0);
  endtask

  initial begin
    dir_row_t dir_rows[DIR_N];
    line_req_t r;
    dir_rows = '{
      '{mk_req(OP_STEP, 0, 0, 0, 0), 1'b1, mk_pix(0, 0, 1'b0, 1'b0)},
      '{mk_req(OP_START, 0, 0, 0, 0), 1'b1, mk_pix(0, 0, 1'b1, 1'b1)},
      '{mk_req(OP_STEP, MAXC, MAXC, MAXC, MAXC), 1'b1, mk_pix(0, 0, 1'b0, 1'b0)},
      '{mk_req(OP_START, MAXC, MAXC, MAXC, MAXC), 1'b1, mk_pix(MAXC, MAXC, 1'b1, 1'b1)},
      '{mk_req(OP_START, 0, 0, 4, 2), 1'b1, mk_pix(0, 0, 1'b0, 1'b1)},
      '{mk_req(OP_STEP, 0, 0, 0, 0), 1'b0, '0},
      '{mk_req(OP_STEP, 0, 0, 0, 0), 1'b0, '0},
      '{mk_req(OP_STEP, 0, 0, 0, 0), 1'b0, '0},
      '{mk_req(OP_STEP, 0, 0, 0, 0), 1'b0, '0},
      '{mk_req(OP_STEP, 0, 0, 0, 0), 1'b1, mk_pix(0, 0, 1'b0, 1'b0)},
      // equal deltas, x major, going left and up
      '{mk_req(OP_START, MAXC, 0, MAXC - 3, 3), 1'b1, mk_pix(MAXC, 0, 1'b0, 1'b1)},
      '{mk_req(OP_STEP, 0, 0, 0, 0), 1'b0, '0},
      '{mk_req(OP_STEP, 0, 0, 0, 0), 1'b0, '0},
      // restart mid-line, steep and going down
      '{mk_req(OP_START, 3, MAXC, 4, MAXC - 5), 1'b1, mk_pix(3, MAXC, 1'b0, 1'b1)},
      '{mk_req(OP_STEP, 0, 0, 0, 0), 1'b0, '0},
      '{mk_req(OP_STEP, 0, 0, 0, 0), 1'b0, '0},
      '{mk_req(OP_STEP, 0, 0, 0, 0), 1'b0, '0},
      '{mk_req(OP_STEP, 0, 0, 0, 0), 1'b0, '0},
      '{mk_req(OP_STEP, 0, 0, 0, 0), 1'b0, '0},
      '{mk_req(OP_START, MAXC, MAXC, MAXC - 5, MAXC - 2), 1'b1,
        mk_pix(MAXC, MAXC, 1'b0, 1'b1)},
      '{mk_req(OP_STEP, 0, 0, 0, 0), 1'b0, '0},
      '{mk_req(OP_STEP, 0, 0, 0, 0), 1'b0, '0},
      '{mk_req(OP_START, 0, 0, MAXC, MAXC), 1'b1, mk_pix(0, 0, 1'b0, 1'b1)},
      '{mk_req(OP_STEP, 0, 0, 0, 0), 1'b0, '0},
      '{mk_req(OP_STEP, 0, 0, 0, 0), 1'b0, '0}
    };
    while (rst) @(posedge clk);
    for (int i = 0; i < DIR_N; i++) begin
      if (dir_rows[i].typed) void'(trace_pixel(dir_rows[i].req));
      send_req(dir_rows[i].req, dir_rows[i].typed, dir_rows[i].pix);
    end
    while (req_count < N_ITEMS) begin
      if ($urandom_range(0, 99) < 85) begin
        run_line();
      end else begin
        r = junk_step();
        if ($urandom_range(0, 3) == 0) r.op = OP_START;
        send_req(r, 1'b0, '0);
      end
    end
    s_axis_tvalid <= 1'b0;
    for (int w = 0; w < 20000 && pending_pixels.size() != 0; w++) @(posedge clk);
    repeat (8) @(posedge clk);
    if (pending_pixels.size() != 0) begin
      $error("%0d pixels never returned", pending_pixels.size());
      err_count++;
    end
    $display("covered %0d requests: %0d line starts, %0d line ends, %0d steps with no line",
             req_count, starts_sent, lines_done, idle_steps);
    $display("with sender and receiver stalls, one long output hold and one full drain");
    if (err_count == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

  // receiver: random holds, plus one long hold that backs up the input
  initial begin
    int n;
    while (rst) @(posedge clk);
    forever begin
      if (hold_req) begin
        m_axis_tready <= 1'b0;
        hold_req = 1'b0;
        n = HOLD_LEN;
      end else if (rx_idle && $urandom_range(0, 4) == 0) begin
        m_axis_tready <= 1'b0;
        n = $urandom_range(1, 18);
      end else begin
        m_axis_tready <= 1'b1;
        n = $urandom_range(1, 12);
      end
      repeat (n) @(posedge clk);
    end
  end

  always @(posedge clk) begin : check_pixels
    pixel_t got, want;
    if (!rst && m_axis_tvalid && m_axis_tready) begin
      got = '{x: m_axis_tdata[CB-1:0], y: m_axis_tdata[2*CB-1:CB],
              last: m_axis_tlast, valid: m_axis_tuser};
      if (got.valid && got.last) lines_done++;
      if (!got.valid) idle_steps++;
      if (pending_pixels.size() == 0) begin
        $error("unexpected pixel x=%0d y=%0d", got.x, got.y);
        err_count++;
      end else begin
        want = pending_pixels.pop_front();
        if (got.x != want.x) begin
          $error("pixel_x: expected %0d, actual %0d", want.x, got.x);
          err_count++;
        end
        if (got.y != want.y) begin
          $error("pixel_y: expected %0d, actual %0d", want.y, got.y);
          err_count++;
        end
        if (got.last != want.last) begin
          $error("is_last: expected %0d, actual %0d", want.last, got.last);
          err_count++;
        end
        if (got.valid != want.valid) begin
          $error("pixel_valid: expected %0d, actual %0d", want.valid, got.valid);
          err_count++;
        end
      end
    end
  end

endmodule
